[hw/rtl/prics_pkg.sv]
// Shared types and constants for the plane radius inverse CDF sampler.
`default_nettype none
package prics_pkg;
   localparam int unsigned RootSteps = 64;
   localparam int unsigned DivSteps  = 64;
   localparam logic [32:0] FloorReset = 33'd4295;
   localparam logic [32:0] OneQ32     = 33'h1_0000_0000;
   localparam int unsigned AddrWidth  = 4;

   // Per-item side information that rides along the long pipes.
   typedef struct packed {
      logic        bad;   // zero distance
      logic        big;   // clamped value reached 1.0, result is zero
      logic [31:0] m;     // clamped one minus alpha, low 32 bits
   } side_type;
endpackage
`default_nettype wire

[hw/rtl/prics_req_if.sv]
// Request channel interface: distance and alpha sample.
`default_nettype none
interface prics_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;
   logic [31:0] alpha_sample;
   modport source (output valid, distance, alpha_sample, input ready);
   modport sink (input valid, distance, alpha_sample, output ready);
endinterface
`default_nettype wire

[hw/rtl/prics_rsp_if.sv]
// Response channel interface: radius and error flag.
`default_nettype none
interface prics_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] radius;
   logic        bad_distance;
   modport source (output valid, radius, bad_distance, input ready);
   modport sink (input valid, radius, bad_distance, output ready);
endinterface
`default_nettype wire

[hw/rtl/prics_isqrt_pipe.sv]
// Bit-per-stage integer square root pipeline over a 128-bit radicand.
`default_nettype none
module prics_isqrt_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [127:0]         in_y,
   input  wire prics_pkg::side_type  in_side,
   output logic                      out_valid,
   output logic [63:0]               out_root,
   output prics_pkg::side_type       out_side
);
   import prics_pkg::*;

   logic [RootSteps-1:0] v_ff;
   logic [64:0]          rem_ff  [RootSteps];
   logic [63:0]          root_ff [RootSteps];
   logic [127:0]         y_ff    [RootSteps];
   side_type             side_ff [RootSteps];

   for (genvar j = 0; j < RootSteps; j++) begin : g_step
      logic         v_prev;
      logic [64:0]  rem_prev;
      logic [63:0]  root_prev;
      logic [127:0] y_prev;
      side_type     side_prev;
      logic [66:0]  cur;
      logic [66:0]  trial;
      logic         ge;
      logic [64:0]  rem_in;
      logic [63:0]  root_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign y_prev    = in_y;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign y_prev    = y_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         cur     = {rem_prev, y_prev[127:126]};
         trial   = {1'b0, root_prev, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? 65'(cur - trial) : cur[64:0];
         root_in = {root_prev[62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            y_ff[j]    <= {y_prev[125:0], 2'b00};
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[RootSteps-1];
   assign out_root  = root_ff[RootSteps-1];
   assign out_side  = side_ff[RootSteps-1];
endmodule
`default_nettype wire

[hw/rtl/prics_div_pipe.sv]
// Restoring divider pipeline, 64-bit dividend by 32-bit divisor, one bit per stage.
`default_nettype none
module prics_div_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          in_num,
   input  wire prics_pkg::side_type  in_side,
   output logic                      out_valid,
   output logic [63:0]               out_quot,
   output prics_pkg::side_type       out_side
);
   import prics_pkg::*;

   logic [DivSteps-1:0] v_ff;
   logic [31:0]         rem_ff  [DivSteps];
   logic [63:0]         num_ff  [DivSteps];
   side_type            side_ff [DivSteps];

   for (genvar j = 0; j < DivSteps; j++) begin : g_step
      logic        v_prev;
      logic [31:0] rem_prev;
      logic [63:0] num_prev;
      side_type    side_prev;
      logic [32:0] cur;
      logic        ge;
      logic [31:0] rem_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign num_prev  = in_num;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign num_prev  = num_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         cur    = {rem_prev, num_prev[63]};
         ge     = (cur >= {1'b0, side_prev.m});
         rem_in = ge ? 32'(cur - {1'b0, side_prev.m}) : cur[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            num_ff[j]  <= {num_prev[62:0], ge};
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[DivSteps-1];
   assign out_quot  = num_ff[DivSteps-1];
   assign out_side  = side_ff[DivSteps-1];
endmodule
`default_nettype wire

[hw/rtl/plane_radius_inverse_cdf_sampler_top.sv]
// Top level of the plane radius inverse CDF sampler pipeline.
`default_nettype none
//  channel | dir | transfer payload                     | handshake
//  req     | in  | distance Q16.16, alpha_sample Q0.32  | valid/ready
//  rsp     | out | radius Q48.16, bad_distance          | valid/ready
//  csr     | in  | clamp floor register at 0x0 (64-bit) | APB, pready tied high
//
//  One transfer per cycle while the response is not stalled; 4 front stages
//  (clamp, squares, partial products, sum), 64 square root stages, 64 divide stages.
//  Synchronous active-high reset clears all valid bits and loads the floor register.
//  A stalled response freezes the whole pipe and holds req.ready low until it is taken.
module plane_radius_inverse_cdf_sampler_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   prics_req_if.sink                          req,
   prics_rsp_if.source                        rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [prics_pkg::AddrWidth-1:0] paddr,
   input  wire logic [63:0]                   pwdata,
   output logic [63:0]                        prdata,
   output logic                               pready
);
   import prics_pkg::*;

   // Floor register.
   logic [32:0] floor_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FloorReset;
      end else if (psel && penable && pwrite && !paddr[3]) begin
         floor_ff <= pwdata[32:0];
      end
   end
   assign pready = 1'b1;
   assign prdata = paddr[3] ? 64'd0 : {31'd0, floor_ff};

   // Freeze everything while the output holds an untaken result.
   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // Stage A: clamp one minus alpha.
   logic [32:0] one_minus;
   logic [32:0] floor_eff;
   logic [32:0] m_clamp;
   always_comb begin
      one_minus = OneQ32 - {1'b0, req.alpha_sample};
      floor_eff = (floor_ff == '0) ? 33'd1 : floor_ff;
      m_clamp   = (floor_eff > one_minus) ? floor_eff : one_minus;
   end

   logic        a_v_ff;
   logic [31:0] a_d_ff;
   side_type    a_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_d_ff        <= req.distance;
         a_side_ff.bad <= (req.distance == '0);
         a_side_ff.big <= m_clamp[32];
         a_side_ff.m   <= m_clamp[31:0];
      end
   end

   // Stage B: D^2 and K = 2^64 - M^2.
   logic        b_v_ff;
   logic [63:0] b_d2_ff;
   logic [63:0] b_k_ff;
   side_type    b_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b_d2_ff   <= 64'(a_d_ff) * 64'(a_d_ff);
         b_k_ff    <= 64'd0 - (64'(a_side_ff.m) * 64'(a_side_ff.m));
         b_side_ff <= a_side_ff;
      end
   end

   // Stage C: four 32x32 partial products of D^2 * K.
   logic        c_v_ff;
   logic [63:0] c_p00_ff, c_p01_ff, c_p10_ff, c_p11_ff;
   side_type    c_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c_p00_ff  <= 64'(b_d2_ff[31:0])  * 64'(b_k_ff[31:0]);
         c_p01_ff  <= 64'(b_d2_ff[31:0])  * 64'(b_k_ff[63:32]);
         c_p10_ff  <= 64'(b_d2_ff[63:32]) * 64'(b_k_ff[31:0]);
         c_p11_ff  <= 64'(b_d2_ff[63:32]) * 64'(b_k_ff[63:32]);
         c_side_ff <= b_side_ff;
      end
   end

   // Stage D: assemble the 128-bit radicand.
   logic         d_v_ff;
   logic [127:0] d_y_ff;
   side_type     d_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= c_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         d_y_ff <= {64'd0, c_p00_ff} + {32'd0, c_p01_ff, 32'd0}
                 + {32'd0, c_p10_ff, 32'd0} + {c_p11_ff, 64'd0};
         d_side_ff <= c_side_ff;
      end
   end

   // Square root, then divide by M.
   logic        s_v;
   logic [63:0] s_root;
   side_type    s_side;
   prics_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .in_y      (d_y_ff),
      .in_side   (d_side_ff),
      .out_valid (s_v),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   logic        q_v;
   logic [63:0] q_quot;
   side_type    q_side;
   prics_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_v),
      .in_num    (s_root),
      .in_side   (s_side),
      .out_valid (q_v),
      .out_quot  (q_quot),
      .out_side  (q_side)
   );

   // Drop the quotient for zero distance or a clamp at 1.0.
   assign rsp.valid        = q_v;
   assign rsp.radius       = (q_side.bad || q_side.big) ? 64'd0 : q_quot;
   assign rsp.bad_distance = q_side.bad;

`ifndef SYNTHESIS
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("req ready disagrees with output stall");
   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_distance |-> rsp.radius == 64'd0)
      else $error("zero distance produced nonzero radius");
   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");
`endif
endmodule
`default_nettype wire
